[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while the synchronous reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Same check with a caller-supplied message.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

`endif

[hdl/sev_pkg.sv]
// ----------------------------------------------------------------------------
// sev_pkg
// Types and constants of the sorted event list.
// ----------------------------------------------------------------------------
package sev_pkg;

    // List depth and derived widths.
    localparam int DEPTH     = 6;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int TIME_W    = 32;
    localparam int TYPE_W    = 3;
    localparam int LOT_W     = 16;
    localparam int CNT_OUT_W = 3;

    // Command codes on the kind field.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    // One stored entry.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] etime;
        logic [TYPE_W-1:0] etype;
        logic [LOT_W-1:0]  lot;
    } t_entry;

    // Command broadcast to every cell.
    typedef struct packed {
        logic              ins;
        logic              pop;
        logic [TIME_W-1:0] etime;
        logic [TYPE_W-1:0] etype;
        logic [LOT_W-1:0]  lot;
    } t_cmd;

endpackage

[hdl/sev_cell.sv]
// ----------------------------------------------------------------------------
// sev_cell
// One slot of the sorted list. It compares its own time with an incoming
// event and takes the new event, its left neighbor, or its right neighbor.
// ----------------------------------------------------------------------------
module sev_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sev_pkg::t_cmd   i_cmd,
    input  sev_pkg::t_entry i_left,
    input  logic           i_left_flag,
    input  sev_pkg::t_entry i_right,
    output sev_pkg::t_entry o_entry,
    output logic           o_flag
);
    import sev_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // The new event belongs at or before this slot.
    assign o_flag  = !r_entry.valid || (r_entry.etime >= i_cmd.etime);
    assign o_entry = r_entry;

    // Select the next contents of the slot.
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins) begin
            if (i_left_flag) begin
                n_entry = i_left;
            end else if (o_flag) begin
                n_entry.valid = 1'b1;
                n_entry.etime = i_cmd.etime;
                n_entry.etype = i_cmd.etype;
                n_entry.lot   = i_cmd.lot;
            end
        end else if (i_cmd.pop) begin
            n_entry = i_right;
        end
    end

    // Only the valid bit is reset; the payload is don't-care while invalid.
    always_ff @(posedge i_clk) begin
        r_entry.etime <= n_entry.etime;
        r_entry.etype <= n_entry.etype;
        r_entry.lot   <= n_entry.lot;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

endmodule

[hdl/sorted_event_list_top.sv]
// ----------------------------------------------------------------------------
// sorted_event_list_top
// Event list kept sorted by time in a row of compare-and-shift cells.
//
//   Channel   Handshake        Beat contents
//   command   start / busy     i_kind, i_event_time, i_event_type, i_lot_tag
//   result    o_strobe         o_popped_*, o_overflow, o_entry_count
//
// A command's result beat shows in the cycle after the command is taken.
// Every cell compares in parallel, so busy stays low and a command may be
// given in every cycle. Reset clears all valid bits and the entry count.
// The result beat is shown for one cycle only.
// ----------------------------------------------------------------------------
module sorted_event_list_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_kind,
    input  logic [sev_pkg::TIME_W-1:0]    i_event_time,
    input  logic [sev_pkg::TYPE_W-1:0]    i_event_type,
    input  logic [sev_pkg::LOT_W-1:0]     i_lot_tag,
    output logic                         o_strobe,
    output logic                         o_popped_valid,
    output logic [sev_pkg::TIME_W-1:0]    o_popped_time,
    output logic [sev_pkg::TYPE_W-1:0]    o_popped_type,
    output logic [sev_pkg::LOT_W-1:0]     o_popped_lot,
    output logic                         o_overflow,
    output logic [sev_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import sev_pkg::*;

    t_cmd             cmd;
    t_entry           entries [DEPTH];
    logic [DEPTH-1:0] flags;
    logic             accept;
    logic             full;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic              r_strobe;
    logic              r_popped_valid;
    logic [TIME_W-1:0] r_popped_time;
    logic [TYPE_W-1:0] r_popped_type;
    logic [LOT_W-1:0]  r_popped_lot;
    logic              r_overflow;

    // No command ever stalls the interface; busy is tied low.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Broadcast command.
    assign cmd.ins   = accept && (i_kind == KIND_INSERT);
    assign cmd.pop   = accept && (i_kind == KIND_POP);
    assign cmd.etime = i_event_time;
    assign cmd.etype = i_event_type;
    assign cmd.lot   = i_lot_tag;

    // Row of cells; the head has no left neighbor, the tail shifts in empty.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry left_e;
        t_entry right_e;
        logic   left_f;

        if (g == 0) begin : g_head
            assign left_e = '0;
            assign left_f = 1'b0;
        end else begin : g_mid
            assign left_e = entries[g-1];
            assign left_f = flags[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign right_e = '0;
        end else begin : g_body
            assign right_e = entries[g+1];
        end

        sev_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cmd       (cmd),
            .i_left      (left_e),
            .i_left_flag (left_f),
            .i_right     (right_e),
            .o_entry     (entries[g]),
            .o_flag      (flags[g])
        );
    end

    assign full = entries[DEPTH-1].valid;

    // Entry count after this command.
    always_comb begin
        n_count = r_count;
        if (cmd.ins && !full) begin
            n_count = r_count + CNT_W'(1);
        end else if (cmd.pop && entries[0].valid) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= accept;
        end
    end

    // Result beat registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_popped_valid <= cmd.pop && entries[0].valid;
            r_overflow     <= cmd.ins && full;
            if (cmd.pop && entries[0].valid) begin
                r_popped_time <= entries[0].etime;
                r_popped_type <= entries[0].etype;
                r_popped_lot  <= entries[0].lot;
            end else begin
                r_popped_time <= '0;
                r_popped_type <= '0;
                r_popped_lot  <= '0;
            end
        end
    end

    assign o_strobe       = r_strobe;
    assign o_popped_valid = r_popped_valid;
    assign o_popped_time  = r_popped_time;
    assign o_popped_type  = r_popped_type;
    assign o_popped_lot   = r_popped_lot;
    assign o_overflow     = r_overflow;
    assign o_entry_count  = CNT_OUT_W'(r_count);

endmodule

[hdl/sev_checker.sv]
// ----------------------------------------------------------------------------
// sev_checker
// Port-level checks of the sorted event list, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sev_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_strobe,
    input logic                         o_popped_valid,
    input logic [sev_pkg::TIME_W-1:0]    o_popped_time,
    input logic [sev_pkg::TYPE_W-1:0]    o_popped_type,
    input logic [sev_pkg::LOT_W-1:0]     o_popped_lot,
    input logic                         o_overflow,
    input logic [sev_pkg::CNT_OUT_W-1:0] o_entry_count
);
    import sev_pkg::*;

    // Each accepted command gives exactly one result beat in the next cycle.
    `ASSERT_CLK(a_beat_follows, i_clk, i_rst_n, (start && !busy) |=> o_strobe)
    `ASSERT_CLK(a_no_stray_beat, i_clk, i_rst_n, !(start && !busy) |=> !o_strobe)

    // A successful pop never reports an overflow.
    `ASSERT_CLK_MSG(a_pop_no_ovf, i_clk, i_rst_n, (o_strobe && o_popped_valid) |-> !o_overflow,
        "pop beat with overflow set")

    // A beat without a popped entry carries a zero payload.
    `ASSERT_CLK(a_zero_payload, i_clk, i_rst_n, (o_strobe && !o_popped_valid) |-> (o_popped_time == '0 && o_popped_type == '0 && o_popped_lot == '0))

    // An overflow leaves the list full.
    `ASSERT_CLK(a_ovf_full, i_clk, i_rst_n, (o_strobe && o_overflow) |-> (o_entry_count == CNT_OUT_W'(DEPTH)))

endmodule

bind sorted_event_list_top sev_checker u_sev_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_popped_valid (o_popped_valid),
    .o_popped_time  (o_popped_time),
    .o_popped_type  (o_popped_type),
    .o_popped_lot   (o_popped_lot),
    .o_overflow     (o_overflow),
    .o_entry_count  (o_entry_count)
);

[tb/sorted_event_list_top_tb.sv]
// ----------------------------------------------------------------------------
// sorted_event_list_top_tb
// Self-checking bench for the time-sorted event list. A directed table walks
// the list through empty, ties, full-list drops and draining; random command
// beats with shifting insert/pop mixes and sender gaps follow. Every result
// beat is checked field by field against a typed-in result or the bench model.
// ----------------------------------------------------------------------------
module sorted_event_list_top_tb;

    import sev_pkg::*;

    localparam int RANDOM_BEATS   = 1150;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 500;

    // Fields of one result beat.
    typedef struct packed {
        logic                 valid;
        logic [TIME_W-1:0]    p_time;
        logic [TYPE_W-1:0]    p_type;
        logic [LOT_W-1:0]     p_lot;
        logic                 ovf;
        logic [CNT_OUT_W-1:0] count;
    } t_list_outcome;

    // One command beat, with an optional typed-in result.
    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] ev_time;
        logic [TYPE_W-1:0] ev_type;
        logic [LOT_W-1:0]  lot;
        logic              pinned;
        t_list_outcome     golden;
    } t_list_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic                 i_kind;
    logic [TIME_W-1:0]    i_event_time;
    logic [TYPE_W-1:0]    i_event_type;
    logic [LOT_W-1:0]     i_lot_tag;
    logic                 o_strobe;
    logic                 o_popped_valid;
    logic [TIME_W-1:0]    o_popped_time;
    logic [TYPE_W-1:0]    o_popped_type;
    logic [LOT_W-1:0]     o_popped_lot;
    logic                 o_overflow;
    logic [CNT_OUT_W-1:0] o_entry_count;

    // Typed-in result that travels with the command beat.
    logic                 cmd_pinned;
    t_list_outcome        cmd_golden;

    // Bench copy of the list contents.
    logic [TIME_W-1:0]    list_time [DEPTH];
    logic [TYPE_W-1:0]    list_type [DEPTH];
    logic [LOT_W-1:0]     list_lot  [DEPTH];
    int                   list_len;

    t_list_outcome        pending_outcomes [$];
    t_list_cmd            directed_plan [$];
    int                   mismatch_count;
    int                   stall_cycles;

    sorted_event_list_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_event_time   (i_event_time),
        .i_event_type   (i_event_type),
        .i_lot_tag      (i_lot_tag),
        .o_strobe       (o_strobe),
        .o_popped_valid (o_popped_valid),
        .o_popped_time  (o_popped_time),
        .o_popped_type  (o_popped_type),
        .o_popped_lot   (o_popped_lot),
        .o_overflow     (o_overflow),
        .o_entry_count  (o_entry_count)
    );

    always #5 i_clk = ~i_clk;

    // Applies one command to the bench list and returns the result it gives.
    function automatic t_list_outcome apply_to_list(logic kind, logic [TIME_W-1:0] t,
                                                    logic [TYPE_W-1:0] ty,
                                                    logic [LOT_W-1:0] lot);
        t_list_outcome res;
        int            pos;
        bit            full;
        res = '0;
        if (kind == KIND_INSERT) begin
            full = (list_len >= DEPTH);
            pos = 0;
            while (pos < list_len && list_time[pos] < t)
                pos++;
            res.ovf = full;
            // A new event later than every entry of a full list falls off itself.
            if (pos < DEPTH) begin
                for (int j = DEPTH - 1; j > pos; j--) begin
                    list_time[j] = list_time[j-1];
                    list_type[j] = list_type[j-1];
                    list_lot[j]  = list_lot[j-1];
                end
                list_time[pos] = t;
                list_type[pos] = ty;
                list_lot[pos]  = lot;
                if (!full)
                    list_len++;
            end
        end else if (list_len > 0) begin
            res.valid  = 1'b1;
            res.p_time = list_time[0];
            res.p_type = list_type[0];
            res.p_lot  = list_lot[0];
            for (int j = 0; j + 1 < DEPTH; j++) begin
                list_time[j] = list_time[j+1];
                list_type[j] = list_type[j+1];
                list_lot[j]  = list_lot[j+1];
            end
            list_len--;
        end
        res.count = CNT_OUT_W'(list_len);
        return res;
    endfunction

    function automatic t_list_cmd plan_row(logic k, logic [TIME_W-1:0] t,
                                           logic [TYPE_W-1:0] ty, logic [LOT_W-1:0] l,
                                           logic pin, logic v, logic [TIME_W-1:0] pt,
                                           logic [TYPE_W-1:0] pty, logic [LOT_W-1:0] pl,
                                           logic ov, logic [CNT_OUT_W-1:0] c);
        t_list_cmd r;
        r.kind    = k;
        r.ev_time = t;
        r.ev_type = ty;
        r.lot     = l;
        r.pinned  = pin;
        r.golden  = '{v, pt, pty, pl, ov, c};
        return r;
    endfunction

    // Random command; times lean toward a small range so that ties are common.
    function automatic t_list_cmd draw_command(int ins_pct);
        t_list_cmd r;
        r = '0;
        r.kind = ($urandom_range(1, 100) <= ins_pct) ? KIND_INSERT : KIND_POP;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r.ev_time = TIME_W'($urandom_range(0, 15));
            4:          r.ev_time = $urandom_range(0, 1) ? '1 : '0;
            default:    r.ev_time = $urandom();
        endcase
        r.ev_type = TYPE_W'($urandom());
        r.lot     = LOT_W'($urandom());
        return r;
    endfunction

    task automatic note_mismatch(string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (got !== want)
            note_mismatch($sformatf("%s: expected %0h, got %0h", name, want, got));
    endtask

    // Drives one command beat and returns at the edge that accepts it.
    task automatic issue_beat(t_list_cmd r);
        start        <= 1'b1;
        i_kind       <= r.kind;
        i_event_time <= r.ev_time;
        i_event_type <= r.ev_type;
        i_lot_tag    <= r.lot;
        cmd_pinned   <= r.pinned;
        cmd_golden   <= r.golden;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    // Sometimes holds start low for a burst, with noise on the command fields.
    task automatic maybe_idle(int pct);
        if ($urandom_range(1, 100) <= pct) begin
            start        <= 1'b0;
            i_kind       <= 1'($urandom());
            i_event_time <= $urandom();
            i_event_type <= TYPE_W'($urandom());
            i_lot_tag    <= LOT_W'($urandom());
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // Result checking and prediction, both on values from before the edge.
    always @(posedge i_clk) begin : result_check
        t_list_outcome seen;
        t_list_outcome want;
        if (i_rst_n) begin
            if (o_strobe === 1'b1) begin
                seen = '{o_popped_valid, o_popped_time, o_popped_type, o_popped_lot,
                         o_overflow, o_entry_count};
                if (pending_outcomes.size() == 0) begin
                    note_mismatch("result beat with nothing expected");
                end else begin
                    want = pending_outcomes.pop_front();
                    check_field("popped_valid", TIME_W'(want.valid), TIME_W'(seen.valid));
                    check_field("popped_time", want.p_time, seen.p_time);
                    check_field("popped_type", TIME_W'(want.p_type), TIME_W'(seen.p_type));
                    check_field("popped_lot", TIME_W'(want.p_lot), TIME_W'(seen.p_lot));
                    check_field("overflow", TIME_W'(want.ovf), TIME_W'(seen.ovf));
                    check_field("entry_count", TIME_W'(want.count), TIME_W'(seen.count));
                end
            end
            if (start && busy === 1'b0) begin
                want = apply_to_list(i_kind, i_event_time, i_event_type, i_lot_tag);
                if (cmd_pinned)
                    want = cmd_golden;
                pending_outcomes.push_back(want);
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_strobe === 1'b1) begin
            stall_cycles = 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_event_list_top: mismatch");
            $finish;
        end else begin
            stall_cycles++;
        end
    end

    // Stimulus: reset, directed table, then random beats.
    initial begin : stimulus
        int ins_pct;
        int gap_pct;
        mismatch_count = 0;
        stall_cycles   = 0;
        list_len       = 0;
        ins_pct        = 50;
        gap_pct        = 30;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_kind       <= KIND_INSERT;
        i_event_time <= '0;
        i_event_type <= '0;
        i_lot_tag    <= '0;
        cmd_pinned   <= 1'b0;
        cmd_golden   <= '0;

        // Pop of an empty list gives an all-zero beat.
        directed_plan.push_back(plan_row(KIND_POP, 32'hDEAD_BEEF, 3'd5, 16'hA5A5,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd0));
        // Fill the list; the second time-100 event goes ahead of the first.
        directed_plan.push_back(plan_row(KIND_INSERT, 32'h0, 3'd0, 16'h0,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd1));
        directed_plan.push_back(plan_row(KIND_INSERT, 32'd300, 3'd7, 16'hFFFF,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd2));
        directed_plan.push_back(plan_row(KIND_INSERT, 32'd100, 3'd3, 16'h1234,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd3));
        directed_plan.push_back(plan_row(KIND_INSERT, 32'd100, 3'd5, 16'h5678,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd4));
        directed_plan.push_back(plan_row(KIND_INSERT, 32'd50, 3'd1, 16'h0001,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd5));
        directed_plan.push_back(plan_row(KIND_INSERT, 32'd200, 3'd2, 16'h00AA,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd6));
        // Full list, new event latest of all: it is lost and overflow is set.
        directed_plan.push_back(plan_row(KIND_INSERT, 32'hFFFF_FFFF, 3'd6, 16'hBEEF,
                                         1'b1, 1'b0, '0, '0, '0, 1'b1, 3'd6));
        // Full list, new event in the middle: the tail entry is dropped.
        directed_plan.push_back(plan_row(KIND_INSERT, 32'd100, 3'd4, 16'h4444,
                                         1'b1, 1'b0, '0, '0, '0, 1'b1, 3'd6));
        // Drain in time order; equal times come out newest first.
        directed_plan.push_back(plan_row(KIND_POP, 32'hFFFF_FFFF, 3'd7, 16'hFFFF,
                                         1'b1, 1'b1, 32'd0, 3'd0, 16'h0, 1'b0, 3'd5));
        directed_plan.push_back(plan_row(KIND_POP, 32'h0, 3'd0, 16'h0,
                                         1'b1, 1'b1, 32'd50, 3'd1, 16'h0001, 1'b0, 3'd4));
        directed_plan.push_back(plan_row(KIND_POP, 32'h1357_9BDF, 3'd2, 16'h0F0F,
                                         1'b1, 1'b1, 32'd100, 3'd4, 16'h4444, 1'b0, 3'd3));
        directed_plan.push_back(plan_row(KIND_POP, 32'h0, 3'd0, 16'h0,
                                         1'b0, 1'b0, '0, '0, '0, 1'b0, 3'd0));
        directed_plan.push_back(plan_row(KIND_POP, 32'h0, 3'd0, 16'h0,
                                         1'b0, 1'b0, '0, '0, '0, 1'b0, 3'd0));
        directed_plan.push_back(plan_row(KIND_POP, 32'h0, 3'd0, 16'h0,
                                         1'b1, 1'b1, 32'd200, 3'd2, 16'h00AA, 1'b0, 3'd0));
        directed_plan.push_back(plan_row(KIND_POP, 32'hFFFF_FFFF, 3'd7, 16'hFFFF,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd0));
        // Extremes of time, type and lot, with a zero time ahead of them.
        directed_plan.push_back(plan_row(KIND_INSERT, 32'hFFFF_FFFF, 3'd7, 16'hFFFF,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd1));
        directed_plan.push_back(plan_row(KIND_INSERT, 32'h0, 3'd0, 16'h0,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd2));
        directed_plan.push_back(plan_row(KIND_POP, 32'h0, 3'd0, 16'h0,
                                         1'b1, 1'b1, 32'h0, 3'd0, 16'h0, 1'b0, 3'd1));
        directed_plan.push_back(plan_row(KIND_POP, 32'h0, 3'd0, 16'h0,
                                         1'b1, 1'b1, 32'hFFFF_FFFF, 3'd7, 16'hFFFF,
                                         1'b0, 3'd0));
        directed_plan.push_back(plan_row(KIND_POP, 32'hFFFF_FFFF, 3'd7, 16'hFFFF,
                                         1'b1, 1'b0, '0, '0, '0, 1'b0, 3'd0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            issue_beat(directed_plan[i]);
            maybe_idle(gap_pct);
        end

        // Random beats in blocks that each keep one insert mix and gap rate.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 3))
                    0:       ins_pct = 25;
                    1:       ins_pct = 50;
                    2:       ins_pct = 75;
                    default: ins_pct = 90;
                endcase
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 20;
                    default: gap_pct = 50;
                endcase
            end
            if (n >= RANDOM_BEATS - QUIET_TAIL)
                gap_pct = 0;
            issue_beat(draw_command(ins_pct));
            maybe_idle(gap_pct);
        end
        start <= 1'b0;

        // Let the last result beats arrive, then a few quiet cycles.
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("sorted_event_list_top: match");
        end else begin
            $display("sorted_event_list_top: mismatch");
        end
        $finish;
    end

endmodule
